[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge out of reset.
`define QDA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define QDA_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hdl/qda_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qda_pkg
// Types, codes and defaults for the quiescence detection agent.
// ---------------------------------------------------------------------------
package qda_pkg;

  localparam int MaxChildrenDef = 8;
  localparam int MaxNodesDef    = 4096;

  typedef enum logic [2:0] {
    KindCreated   = 3'd0,
    KindProcessed = 3'd1,
    KindControl   = 3'd2,
    KindAnnounce  = 3'd3,
    KindStart     = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    DestChildren  = 3'd0,
    DestSelf      = 3'd1,
    DestParent    = 3'd2,
    DestRoot      = 3'd3,
    DestBroadcast = 3'd4,
    DestQuiescent = 3'd5,
    DestError     = 3'd6
  } dest_e;

  typedef enum logic [1:0] {
    PhaseStart = 2'd0,
    PhaseSum   = 2'd1,
    PhaseDirty = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    CfgIsRoot      = 2'd0,
    CfgNumChildren = 2'd1,
    CfgNumNodes    = 2'd2,
    CfgParentId    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StSum   = 3'b010,
    StDirty = 3'b100
  } stage_e;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] delta;
    logic [1:0]         msg_phase;
    logic signed [31:0] msg_created;
    logic signed [31:0] msg_processed;
    logic               msg_dirty;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         dest;
    logic [11:0]        target_node;
    logic [1:0]         out_phase;
    logic signed [31:0] out_created;
    logic signed [31:0] out_processed;
    logic               out_dirty;
    logic               last;
  } out_word_t;

  function automatic out_word_t make_word(logic [2:0] dest, logic [11:0] target,
                                          logic [1:0] phase, logic [31:0] created,
                                          logic [31:0] processed, logic dirty);
    out_word_t w;
    w.dest          = dest;
    w.target_node   = target;
    w.out_phase     = phase;
    w.out_created   = created;
    w.out_processed = processed;
    w.out_dirty     = dirty;
    w.last          = 1'b0;
    return w;
  endfunction

endpackage

[hdl/quiescence_detection_agent.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quiescence_detection_agent
// Per-node agent for two-wave quiescence detection over a spanning tree.
// ---------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one event word (delta, control
// message, announce or start). Output channel: out_valid_o / out_stall_i
// carry result words; an event yields zero, one or two words, and the final
// word of an event has last set.
// Configuration: cfg_we_i writes cfg_data_i into the register at cfg_idx_i
// (is_root, num_children, num_nodes, parent_id); write only while idle.
// An event's result words are written into the queue below in the accepting
// cycle. The agent takes one event per cycle while in_stall_o is low; its
// state updates in the accepting cycle, so events wait only on the queue.
// Result words go into a four-word queue; the input stalls while more than
// two words are queued, so a stalled receiver throttles events once the
// queue fills, and a two-word event takes two entries of the queue.
// Reset clears all counters, the wave stage and the queue, and loads the
// configuration defaults (not root, no children, one node, parent zero).
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module quiescence_detection_agent #(
  parameter int MaxChildren = qda_pkg::MaxChildrenDef,
  parameter int MaxNodes    = qda_pkg::MaxNodesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  qda_pkg::in_word_t in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output qda_pkg::out_word_t out_word_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [12:0]       cfg_data_i
);

  logic        is_root_q;
  logic [3:0]  num_children_q;
  logic [12:0] num_nodes_q;
  logic [11:0] parent_id_q;

  logic [31:0] cc_q, cc_d, pc_q, pc_d, ps_q, ps_d, sc_q, sc_d, sp_q, sp_d;
  logic        sd_q, sd_d;
  logic [4:0]  rc_q, rc_d;
  qda_pkg::stage_e stage_q, stage_d;

  qda_pkg::out_word_t fifo_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;

  qda_pkg::out_word_t res0, res1;
  logic [1:0]  nres;
  logic        in_acc, pop;
  logic        do_w1, do_w2, clear;
  logic [3:0]  kids;
  logic [12:0] nodes;
  logic [31:0] cc_mc, sc_sum, sp_sum;
  logic [4:0]  rc_inc;
  logic        all_rep, gt, dirty_cur, dirty_p2;

  assign in_stall_o  = count_q > 3'd2;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = count_q != 3'd0;
  assign out_word_o  = fifo_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  assign kids  = ({28'd0, num_children_q} > 32'(MaxChildren)) ? 4'(MaxChildren)
                                                             : num_children_q;
  assign nodes = ({19'd0, num_nodes_q} > 32'(MaxNodes)) ? 13'(MaxNodes) : num_nodes_q;

  assign sc_sum    = sc_q + in_word_i.msg_created;
  assign sp_sum    = sp_q + in_word_i.msg_processed;
  assign rc_inc    = rc_q + 5'd1;
  assign all_rep   = rc_inc >= ({1'b0, kids} + 5'd1);
  assign gt        = $signed(pc_q) > $signed(ps_q);
  assign dirty_cur = gt || sd_q;
  assign dirty_p2  = gt || sd_q || in_word_i.msg_dirty;
  assign cc_mc     = cc_q - {28'd0, kids};

  always_comb begin
    cc_d    = cc_q;
    pc_d    = pc_q;
    ps_d    = ps_q;
    sc_d    = sc_q;
    sp_d    = sp_q;
    sd_d    = sd_q;
    rc_d    = rc_q;
    stage_d = stage_q;
    res0    = '0;
    res1    = '0;
    nres    = 2'd0;
    do_w1   = 1'b0;
    do_w2   = 1'b0;
    clear   = 1'b0;
    if (in_acc) begin
      case (in_word_i.kind)
        qda_pkg::KindCreated: cc_d = cc_q + in_word_i.delta;
        qda_pkg::KindProcessed: pc_d = pc_q + in_word_i.delta;
        qda_pkg::KindControl: begin
          case (in_word_i.msg_phase)
            qda_pkg::PhaseStart: begin
              do_w1 = (stage_q == qda_pkg::StIdle);
            end
            qda_pkg::PhaseSum: begin
              if (stage_q == qda_pkg::StIdle) begin
                do_w2 = 1'b1;
              end else if (stage_q == qda_pkg::StSum) begin
                sc_d = sc_sum;
                sp_d = sp_sum;
                rc_d = rc_inc;
                if (all_rep) begin
                  if (is_root_q) begin
                    do_w2 = (sc_sum == sp_sum);
                    do_w1 = (sc_sum != sp_sum);
                  end else begin
                    res0    = qda_pkg::make_word(qda_pkg::DestParent, parent_id_q,
                                                 qda_pkg::PhaseSum, sc_sum, sp_sum, 1'b0);
                    nres    = 2'd1;
                    cc_d    = cc_q - 32'd1;
                    clear   = 1'b1;
                    stage_d = qda_pkg::StIdle;
                  end
                end
              end else begin
                res0 = qda_pkg::make_word(qda_pkg::DestError, '0, '0, '0, '0, 1'b0);
                nres = 2'd1;
              end
            end
            qda_pkg::PhaseDirty: begin
              if (stage_q == qda_pkg::StDirty) begin
                sd_d = sd_q | in_word_i.msg_dirty;
                rc_d = rc_inc;
                if (all_rep) begin
                  if (is_root_q && dirty_p2) begin
                    do_w1 = 1'b1;
                  end else if (is_root_q) begin
                    res0    = qda_pkg::make_word(qda_pkg::DestBroadcast, '0, '0, '0, '0,
                                                 1'b0);
                    nres    = 2'd1;
                    cc_d    = cc_q - {19'd0, nodes};
                    clear   = 1'b1;
                    stage_d = qda_pkg::StIdle;
                  end else begin
                    res0    = qda_pkg::make_word(qda_pkg::DestParent, parent_id_q,
                                                 qda_pkg::PhaseDirty, '0, '0, dirty_p2);
                    nres    = 2'd1;
                    cc_d    = cc_q - 32'd1;
                    clear   = 1'b1;
                    stage_d = qda_pkg::StIdle;
                  end
                end
              end else begin
                res0 = qda_pkg::make_word(qda_pkg::DestError, '0, '0, '0, '0, 1'b0);
                nres = 2'd1;
              end
            end
            default: begin
              res0 = qda_pkg::make_word(qda_pkg::DestError, '0, '0, '0, '0, 1'b0);
              nres = 2'd1;
            end
          endcase
        end
        qda_pkg::KindAnnounce: begin
          res0 = qda_pkg::make_word(qda_pkg::DestQuiescent, '0, '0, '0, '0, 1'b0);
          nres = 2'd1;
        end
        qda_pkg::KindStart: begin
          cc_d = cc_q - 32'd1;
          res0 = qda_pkg::make_word(qda_pkg::DestRoot, '0, '0, '0, '0, 1'b0);
          nres = 2'd1;
        end
        default: ;
      endcase
    end

    if (do_w1 || do_w2) begin
      if (do_w1) begin
        res1    = qda_pkg::make_word(qda_pkg::DestSelf, '0, qda_pkg::PhaseSum, cc_mc,
                                     pc_q, 1'b0);
        ps_d    = pc_q;
        stage_d = qda_pkg::StSum;
      end else begin
        res1    = qda_pkg::make_word(qda_pkg::DestSelf, '0, qda_pkg::PhaseDirty, '0, '0,
                                     dirty_cur);
        stage_d = qda_pkg::StDirty;
      end
      if (kids != 4'd0) begin
        res0 = qda_pkg::make_word(qda_pkg::DestChildren, '0,
                                  do_w1 ? qda_pkg::PhaseStart : qda_pkg::PhaseSum,
                                  '0, '0, 1'b0);
        nres = 2'd2;
      end else begin
        res0 = res1;
        nres = 2'd1;
      end
      cc_d  = cc_mc - 32'd1;
      clear = 1'b1;
    end

    if (clear) begin
      rc_d = '0;
      sc_d = '0;
      sp_d = '0;
      sd_d = 1'b0;
    end

    if (nres == 2'd1) begin
      res0.last = 1'b1;
    end
    if (nres == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_root_q      <= 1'b0;
      num_children_q <= '0;
      num_nodes_q    <= 13'd1;
      parent_id_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qda_pkg::CfgIsRoot:      is_root_q      <= cfg_data_i[0];
        qda_pkg::CfgNumChildren: num_children_q <= cfg_data_i[3:0];
        qda_pkg::CfgNumNodes:    num_nodes_q    <= cfg_data_i;
        qda_pkg::CfgParentId:    parent_id_q    <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q    <= '0;
      pc_q    <= '0;
      ps_q    <= '0;
      sc_q    <= '0;
      sp_q    <= '0;
      sd_q    <= 1'b0;
      rc_q    <= '0;
      stage_q <= qda_pkg::StIdle;
    end else begin
      cc_q    <= cc_d;
      pc_q    <= pc_d;
      ps_q    <= ps_d;
      sc_q    <= sc_d;
      sp_q    <= sp_d;
      sd_q    <= sd_d;
      rc_q    <= rc_d;
      stage_q <= stage_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + nres;
      rd_ptr_q <= rd_ptr_q + {1'b0, pop};
      count_q  <= count_q + {1'b0, nres} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (nres != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (nres == 2'd2) begin
      fifo_q[wr_ptr_q + 2'd1] <= res1;
    end
  end

  `QDA_ASSERT_ALWAYS(a_queue_bound, count_q <= 3'd4, "result queue overflow")
  `QDA_ASSERT_IMPLIES(a_push_fits, in_acc, ({1'b0, count_q} + {2'b00, nres}) <= 4'd4,
    "accepted event does not fit the result queue")
  `QDA_ASSERT_IMPLIES(a_idle_no_reports, stage_q == qda_pkg::StIdle, rc_q == 5'd0,
    "report count left over outside a wave")
  `QDA_ASSERT_ALWAYS(a_report_bound, rc_q <= 5'd16, "report count out of range")

endmodule
